>>> design/hrlt_pkg.sv
`timescale 1ns / 1ps

package hrlt_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_KEYWORD = 4'd0,
    PH_PATH    = 4'd1,
    PH_QUERY   = 4'd2,
    PH_VERSION = 4'd3,
    PH_LFSKIP  = 4'd4,
    PH_HSTART  = 4'd5,
    PH_HMATCH  = 4'd6,
    PH_HVALUE  = 4'd7,
    PH_HUNK    = 4'd8,
    PH_DONE    = 4'd9,
    PH_REJECT  = 4'd10
  } phase_t;

  // Byte tags
  localparam logic [3:0] TAG_KEYWORD    = 4'd0;
  localparam logic [3:0] TAG_PATH       = 4'd1;
  localparam logic [3:0] TAG_QUERY_MARK = 4'd2;
  localparam logic [3:0] TAG_QUERY      = 4'd3;
  localparam logic [3:0] TAG_VER_MARK   = 4'd4;
  localparam logic [3:0] TAG_VERSION    = 4'd5;
  localparam logic [3:0] TAG_LINE_END   = 4'd6;
  localparam logic [3:0] TAG_HDR_PREFIX = 4'd7;
  localparam logic [3:0] TAG_HDR_VALUE  = 4'd8;
  localparam logic [3:0] TAG_HDR_UNK    = 4'd9;
  localparam logic [3:0] TAG_AFTER_END  = 4'd10;
  localparam logic [3:0] TAG_REJECTED   = 4'd11;

  // Parse status codes
  localparam logic [1:0] ST_PARSING  = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_BAD_REQ  = 2'd2;
  localparam logic [1:0] ST_NOT_IMPL = 2'd3;

  // Method codes that are served
  localparam logic [2:0] METH_GET  = 3'd0;
  localparam logic [2:0] METH_HEAD = 3'd1;

  localparam logic [2:0] HDR_NONE = 3'd0;

  localparam int NUM_METHODS = 8;
  localparam int NUM_HEADERS = 6;
  localparam int MW_BYTES    = 11;
  localparam int HW_BYTES    = 17;
  localparam logic [4:0] POS_MAX = 5'd31;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_QM  = 8'h3F;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Keywords, right-aligned and zero-padded on the left
  localparam logic [MW_BYTES*8-1:0] METHOD_WORDS [NUM_METHODS] = '{
    "get ", "head ", "textsearch ", "checkout ",
    "checkin ", "put ", "post ", "showmethod "
  };
  localparam logic [4:0] METHOD_LENS [NUM_METHODS] = '{
    5'd4, 5'd5, 5'd11, 5'd9, 5'd8, 5'd4, 5'd5, 5'd11
  };

  localparam logic [HW_BYTES*8-1:0] HEADER_WORDS [NUM_HEADERS] = '{
    "from: ", "authorization: ", "accept: ",
    "accept-encoding: ", "useragent: ", "referee uri: "
  };
  localparam logic [4:0] HEADER_LENS [NUM_HEADERS] = '{
    5'd6, 5'd15, 5'd8, 5'd17, 5'd11, 5'd13
  };

  // Classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] ch;      // lower-cased byte
    logic       is_cr;
    logic       is_lf;
    logic       is_nul;
    logic       is_qm;
    logic       is_sp;
    logic       first;
  } item_t;

  typedef struct packed {
    logic [3:0] byte_tag;
    logic [2:0] method_code;
    logic [1:0] parse_status;
    logic [2:0] header_kind;
    logic       request_complete;
  } result_t;

  // Character of keyword i at position pos; meaningful only when pos < length
  function automatic logic [7:0] method_char(input logic [2:0] i, input logic [4:0] pos);
    logic [MW_BYTES*8-1:0] w;
    logic [4:0]            d;
    logic [3:0]            k;
    w = METHOD_WORDS[i];
    d = METHOD_LENS[i] - 5'd1 - pos;
    k = d[3:0];
    return w[{k, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] header_char(input logic [2:0] i, input logic [4:0] pos);
    logic [HW_BYTES*8-1:0] w;
    logic [4:0]            k;
    w = HEADER_WORDS[i];
    k = HEADER_LENS[i] - 5'd1 - pos;
    return w[{k, 3'b000} +: 8];
  endfunction

endpackage

>>> design/hrlt_front.sv
`timescale 1ns / 1ps

module hrlt_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first_byte,
  input  logic                q_full,
  output logic                push,
  output hrlt_pkg::item_t     item
);
  import hrlt_pkg::*;

  logic is_upper;

  // Take a beat whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign is_upper = (in_data_byte >= 8'h41) && (in_data_byte <= 8'h5A);

  always_comb begin
    item.ch     = is_upper ? (in_data_byte + 8'h20) : in_data_byte;
    item.is_cr  = (in_data_byte == CH_CR);
    item.is_lf  = (in_data_byte == CH_LF);
    item.is_nul = (in_data_byte == CH_NUL);
    item.is_qm  = (in_data_byte == CH_QM);
    item.is_sp  = (in_data_byte == CH_SP);
    item.first  = in_first_byte;
  end

endmodule

>>> design/hrlt_queue.sv
`timescale 1ns / 1ps

module hrlt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hrlt_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output hrlt_pkg::item_t  q_item
);
  import hrlt_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/hrlt_back.sv
`timescale 1ns / 1ps

module hrlt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  hrlt_pkg::item_t     q_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output hrlt_pkg::result_t   result
);
  import hrlt_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic [7:0] mcand_r, mcand_nxt;
  logic [5:0] hcand_r, hcand_nxt;
  logic [2:0] meth_r, meth_nxt;
  logic [2:0] hdr_r, hdr_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic       out_valid_r;
  result_t    result_r, result_nxt;

  phase_t     e_phase;
  logic [4:0] e_pos;
  logic [7:0] e_mcand;
  logic [5:0] e_hcand;
  logic [2:0] e_meth;
  logic [2:0] e_hdr;
  logic [1:0] e_stat;

  logic [7:0] m_ok, m_hit;
  logic       m_any;
  logic [2:0] m_idx;
  logic       h_start;
  logic [5:0] hc_in;
  logic [4:0] hp_in;
  logic [5:0] h_ok, h_hit;
  logic       h_any;
  logic [2:0] h_idx;
  logic       do_hname;
  logic [3:0] tag;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign result    = result_r;

  always_comb begin
    // Restart on the first byte of a request
    if (q_item.first) begin
      e_phase = PH_KEYWORD;
      e_pos   = '0;
      e_mcand = '1;
      e_hcand = '1;
      e_meth  = '0;
      e_hdr   = HDR_NONE;
      e_stat  = ST_PARSING;
    end else begin
      e_phase = phase_r;
      e_pos   = pos_r;
      e_mcand = mcand_r;
      e_hcand = hcand_r;
      e_meth  = meth_r;
      e_hdr   = hdr_r;
      e_stat  = stat_r;
    end

    // Keyword candidates, all compared in parallel
    m_any = 1'b0;
    m_idx = '0;
    for (int i = 0; i < NUM_METHODS; i++) begin
      m_ok[i]  = e_mcand[i] && (e_pos < METHOD_LENS[i]) &&
                 (method_char(3'(i), e_pos) == q_item.ch);
      m_hit[i] = m_ok[i] && ((e_pos + 5'd1) == METHOD_LENS[i]);
      if (m_hit[i]) begin
        m_any = 1'b1;
        m_idx = 3'(i);
      end
    end

    // Header name candidates; a new line starts afresh
    h_start = ((e_phase == PH_LFSKIP) && !q_item.is_lf) || (e_phase == PH_HSTART);
    hc_in   = h_start ? '1 : e_hcand;
    hp_in   = h_start ? '0 : e_pos;
    h_any = 1'b0;
    h_idx = '0;
    for (int i = 0; i < NUM_HEADERS; i++) begin
      h_ok[i]  = hc_in[i] && (hp_in < HEADER_LENS[i]) &&
                 (header_char(3'(i), hp_in) == q_item.ch);
      h_hit[i] = h_ok[i] && ((hp_in + 5'd1) == HEADER_LENS[i]);
      if (h_hit[i]) begin
        h_any = 1'b1;
        h_idx = 3'(i);
      end
    end

    phase_nxt = e_phase;
    pos_nxt   = e_pos;
    mcand_nxt = e_mcand;
    hcand_nxt = e_hcand;
    meth_nxt  = e_meth;
    hdr_nxt   = e_hdr;
    stat_nxt  = e_stat;
    tag       = TAG_AFTER_END;
    do_hname  = 1'b0;

    case (e_phase)
      PH_KEYWORD: begin
        mcand_nxt = m_ok;
        if (m_any) begin
          meth_nxt = m_idx;
          tag      = TAG_KEYWORD;
          if (m_idx == METH_GET || m_idx == METH_HEAD) begin
            stat_nxt  = ST_ACCEPTED;
            phase_nxt = PH_PATH;
          end else begin
            stat_nxt  = ST_NOT_IMPL;
            phase_nxt = PH_REJECT;
          end
        end else if (m_ok == '0) begin
          stat_nxt  = ST_BAD_REQ;
          phase_nxt = PH_REJECT;
          tag       = TAG_REJECTED;
        end else begin
          tag = TAG_KEYWORD;
          if (e_pos < POS_MAX) begin
            pos_nxt = e_pos + 5'd1;
          end
        end
      end
      PH_PATH, PH_QUERY: begin
        if (q_item.is_qm) begin
          tag       = TAG_QUERY_MARK;
          phase_nxt = PH_QUERY;
        end else if (q_item.is_sp) begin
          tag       = TAG_VER_MARK;
          phase_nxt = PH_VERSION;
        end else if (q_item.is_cr) begin
          tag       = TAG_LINE_END;
          phase_nxt = PH_LFSKIP;
        end else if (q_item.is_nul) begin
          tag       = TAG_LINE_END;
          phase_nxt = PH_DONE;
        end else begin
          tag = (e_phase == PH_PATH) ? TAG_PATH : TAG_QUERY;
        end
      end
      PH_VERSION: begin
        if (q_item.is_cr) begin
          tag       = TAG_LINE_END;
          phase_nxt = PH_LFSKIP;
        end else if (q_item.is_nul) begin
          tag       = TAG_LINE_END;
          phase_nxt = PH_DONE;
        end else begin
          tag = TAG_VERSION;
        end
      end
      PH_LFSKIP, PH_HSTART: begin
        if (e_phase == PH_LFSKIP && q_item.is_lf) begin
          tag       = TAG_LINE_END;
          phase_nxt = PH_HSTART;
        end else begin
          hdr_nxt = HDR_NONE;
          if (q_item.is_cr || q_item.is_nul) begin
            tag       = TAG_LINE_END;
            phase_nxt = PH_DONE;
          end else begin
            hcand_nxt = '1;
            pos_nxt   = '0;
            do_hname  = 1'b1;
          end
        end
      end
      PH_HMATCH: begin
        do_hname = 1'b1;
      end
      PH_HVALUE, PH_HUNK: begin
        if (q_item.is_cr) begin
          tag       = TAG_LINE_END;
          phase_nxt = PH_LFSKIP;
        end else if (q_item.is_nul) begin
          tag       = TAG_LINE_END;
          phase_nxt = PH_DONE;
        end else begin
          tag = (e_phase == PH_HVALUE) ? TAG_HDR_VALUE : TAG_HDR_UNK;
        end
      end
      PH_REJECT: begin
        tag = TAG_REJECTED;
      end
      default: begin
        phase_nxt = PH_DONE;
        tag       = TAG_AFTER_END;
      end
    endcase

    // Byte inside a header name
    if (do_hname) begin
      if (q_item.is_cr) begin
        tag       = TAG_LINE_END;
        phase_nxt = PH_LFSKIP;
      end else if (q_item.is_nul) begin
        tag       = TAG_LINE_END;
        phase_nxt = PH_DONE;
      end else begin
        hcand_nxt = h_ok;
        if (h_any) begin
          hdr_nxt   = h_idx + 3'd1;
          phase_nxt = PH_HVALUE;
          tag       = TAG_HDR_PREFIX;
        end else if (h_ok == '0) begin
          phase_nxt = PH_HUNK;
          tag       = TAG_HDR_UNK;
        end else begin
          phase_nxt = PH_HMATCH;
          tag       = TAG_HDR_PREFIX;
          pos_nxt   = (hp_in < POS_MAX) ? hp_in + 5'd1 : hp_in;
        end
      end
    end

    result_nxt.byte_tag         = tag;
    result_nxt.method_code      = meth_nxt;
    result_nxt.parse_status     = stat_nxt;
    result_nxt.header_kind      = hdr_nxt;
    result_nxt.request_complete = (phase_nxt == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_KEYWORD;
      pos_r       <= '0;
      mcand_r     <= '1;
      hcand_r     <= '1;
      meth_r      <= '0;
      hdr_r       <= HDR_NONE;
      stat_r      <= ST_PARSING;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        mcand_r <= mcand_nxt;
        hcand_r <= hcand_nxt;
        meth_r  <= meth_nxt;
        hdr_r   <= hdr_nxt;
        stat_r  <= stat_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_r <= result_nxt;
    end
  end

endmodule

>>> design/http_request_line_tagger_core.sv
// Path: an accepted byte is written into the queue, then parsed and registered in the result
//   register that drives the out_ ports; a stall can hold it in the queue between the two.
// Throughput: one byte per cycle while out_stall is low; the parser step in the back part settles
//   all keyword and header-name comparisons for a byte combinationally.
// A two-entry queue sits between classifier and parser, so in_stall rises only when it is full.
// Reset (synchronous, rst_n low): queue emptied, no result pending, parser back in keyword phase.
`timescale 1ns / 1ps

module http_request_line_tagger_core (
  input  logic       clk,
  input  logic       rst_n,
  // input channel: one request byte per beat
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  // result channel: one tagged byte per beat
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_byte_tag,
  output logic [2:0] out_method_code,
  output logic [1:0] out_parse_status,
  output logic [2:0] out_header_kind,
  output logic       out_request_complete
);
  import hrlt_pkg::*;

  logic    push;
  logic    q_full;
  item_t   push_item;
  logic    q_valid;
  item_t   q_item;
  logic    pop;
  result_t result;

  // Front: take the beat, lower-case the byte and flag the delimiters
  hrlt_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .q_full        (q_full),
    .push          (push),
    .item          (push_item)
  );

  // Queue: hold classified bytes while the result side stalls
  hrlt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Back: advance the parser by one byte and register the tagged result.
  // The result register refills in the cycle it is taken; the parser waits only while a result is stalled.
  hrlt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign out_byte_tag         = result.byte_tag;
  assign out_method_code      = result.method_code;
  assign out_parse_status     = result.parse_status;
  assign out_header_kind      = result.header_kind;
  assign out_request_complete = result.request_complete;

endmodule

>>> verif/tb_http_request_line_tagger_core.sv
`timescale 1ns / 1ps

module tb_http_request_line_tagger_core;
  import hrlt_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_first_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_byte_tag;
  logic [2:0] out_method_code;
  logic [1:0] out_parse_status;
  logic [2:0] out_header_kind;
  logic       out_request_complete;

  http_request_line_tagger_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_first_byte        (in_first_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_byte_tag         (out_byte_tag),
    .out_method_code      (out_method_code),
    .out_parse_status     (out_parse_status),
    .out_header_kind      (out_header_kind),
    .out_request_complete (out_request_complete)
  );

  always #4 clk = ~clk;

  // Tagger state as the testbench tracks it, one beat ahead of the block
  phase_t     tg_phase;
  logic [4:0] tg_pos;
  logic [7:0] tg_meth_cand;
  logic [5:0] tg_hdr_cand;
  logic [2:0] tg_method;
  logic [2:0] tg_header;
  logic [1:0] tg_status;

  result_t    expected_tags [$];
  logic [7:0] req_text [$];
  int         bytes_sent = 0;
  int         results_seen = 0;
  int         mismatch_count = 0;
  int         hold_cycles = 0;
  bit         tx_gaps_on = 1'b1;
  bit         rx_gaps_on = 1'b1;

  function automatic string method_text(input int i);
    case (i)
      0: return "get ";
      1: return "head ";
      2: return "textsearch ";
      3: return "checkout ";
      4: return "checkin ";
      5: return "put ";
      6: return "post ";
      default: return "showmethod ";
    endcase
  endfunction

  function automatic string header_text(input int i);
    case (i)
      0: return "from: ";
      1: return "authorization: ";
      2: return "accept: ";
      3: return "accept-encoding: ";
      4: return "useragent: ";
      default: return "referee uri: ";
    endcase
  endfunction

  // Drop every candidate word that disagrees at pos; flag the one that ends here
  function automatic logic [7:0] drop_mismatches(input logic [7:0] cand, input bit hdr,
                                                 input logic [4:0] pos, input logic [7:0] ch,
                                                 output int hit);
    string w;
    int    i;
    hit = -1;
    for (i = 0; i < (hdr ? NUM_HEADERS : NUM_METHODS); i++) begin
      if (cand[i]) begin
        w = hdr ? header_text(i) : method_text(i);
        if (pos >= w.len() || w[pos] != ch) cand[i] = 1'b0;
        else if (pos + 1 == w.len()) hit = i;
      end
    end
    return cand;
  endfunction

  function automatic void clear_tagger_state();
    tg_phase     = PH_KEYWORD;
    tg_pos       = 5'd0;
    tg_meth_cand = 8'hFF;
    tg_hdr_cand  = 6'h3F;
    tg_method    = METH_GET;
    tg_header    = HDR_NONE;
    tg_status    = ST_PARSING;
  endfunction

  function automatic logic [3:0] header_name_tag(input logic [7:0] c);
    int hit;
    if (c == CH_CR) begin
      tg_phase = PH_LFSKIP;
      return TAG_LINE_END;
    end
    if (c == CH_NUL) begin
      tg_phase = PH_DONE;
      return TAG_LINE_END;
    end
    tg_hdr_cand = 6'(drop_mismatches({2'b00, tg_hdr_cand}, 1'b1, tg_pos, c, hit));
    if (hit >= 0) begin
      tg_header = 3'(hit + 1);
      tg_phase  = PH_HVALUE;
      return TAG_HDR_PREFIX;
    end
    if (tg_hdr_cand == 6'h00) begin
      tg_phase = PH_HUNK;
      return TAG_HDR_UNK;
    end
    if (tg_pos < POS_MAX) tg_pos++;
    return TAG_HDR_PREFIX;
  endfunction

  // First byte of a header line: a bare CR or NUL here ends the request
  function automatic logic [3:0] line_start_tag(input logic [7:0] c);
    tg_header = HDR_NONE;
    if (c == CH_CR || c == CH_NUL) begin
      tg_phase = PH_DONE;
      return TAG_LINE_END;
    end
    tg_hdr_cand = 6'h3F;
    tg_pos      = 5'd0;
    tg_phase    = PH_HMATCH;
    return header_name_tag(c);
  endfunction

  // Advance the tracked state by one request byte and form the tagged result
  function automatic result_t tag_request_byte(input logic [7:0] b, input logic restart);
    logic [7:0] lc;
    logic [3:0] tag;
    int         hit;
    result_t    r;
    if (restart) clear_tagger_state();
    lc  = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    tag = TAG_AFTER_END;
    case (tg_phase)
      PH_KEYWORD: begin
        tg_meth_cand = drop_mismatches(tg_meth_cand, 1'b0, tg_pos, lc, hit);
        if (hit >= 0) begin
          tg_method = 3'(hit);
          if (hit <= int'(METH_HEAD)) begin
            tg_status = ST_ACCEPTED;
            tg_phase  = PH_PATH;
          end else begin
            tg_status = ST_NOT_IMPL;
            tg_phase  = PH_REJECT;
          end
          tag = TAG_KEYWORD;
        end else if (tg_meth_cand == 8'h00) begin
          tg_status = ST_BAD_REQ;
          tg_phase  = PH_REJECT;
          tag       = TAG_REJECTED;
        end else begin
          if (tg_pos < POS_MAX) tg_pos++;
          tag = TAG_KEYWORD;
        end
      end
      PH_PATH, PH_QUERY: begin
        if (b == CH_QM) begin
          tag      = TAG_QUERY_MARK;
          tg_phase = PH_QUERY;
        end else if (b == CH_SP) begin
          tag      = TAG_VER_MARK;
          tg_phase = PH_VERSION;
        end else if (b == CH_CR) begin
          tag      = TAG_LINE_END;
          tg_phase = PH_LFSKIP;
        end else if (b == CH_NUL) begin
          tag      = TAG_LINE_END;
          tg_phase = PH_DONE;
        end else begin
          tag = (tg_phase == PH_PATH) ? TAG_PATH : TAG_QUERY;
        end
      end
      PH_VERSION: begin
        if (b == CH_CR) begin
          tag      = TAG_LINE_END;
          tg_phase = PH_LFSKIP;
        end else if (b == CH_NUL) begin
          tag      = TAG_LINE_END;
          tg_phase = PH_DONE;
        end else begin
          tag = TAG_VERSION;
        end
      end
      PH_LFSKIP: begin
        if (b == CH_LF) begin
          tag      = TAG_LINE_END;
          tg_phase = PH_HSTART;
        end else begin
          tag = line_start_tag(lc);
        end
      end
      PH_HSTART: tag = line_start_tag(lc);
      PH_HMATCH: tag = header_name_tag(lc);
      PH_HVALUE, PH_HUNK: begin
        if (b == CH_CR) begin
          tag      = TAG_LINE_END;
          tg_phase = PH_LFSKIP;
        end else if (b == CH_NUL) begin
          tag      = TAG_LINE_END;
          tg_phase = PH_DONE;
        end else begin
          tag = (tg_phase == PH_HVALUE) ? TAG_HDR_VALUE : TAG_HDR_UNK;
        end
      end
      PH_REJECT: tag = TAG_REJECTED;
      default: begin
        tg_phase = PH_DONE;
        tag      = TAG_AFTER_END;
      end
    endcase
    r.byte_tag         = tag;
    r.method_code      = tg_method;
    r.parse_status     = tg_status;
    r.header_kind      = tg_header;
    r.request_complete = (tg_phase == PH_DONE);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    $display("%0t: beat %0d %s: expected %0d, got %0d", $time, results_seen, what, want, got);
  endtask

  // Offer one byte, hold it until the beat is taken, then log what it should give
  task automatic send_byte(input logic [7:0] b, input logic restart);
    if (tx_gaps_on && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_first_byte <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_tags.push_back(tag_request_byte(b, restart));
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit restart);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], restart && i == 0);
  endtask

  // Drop valid and hold until every beat sent so far has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_tags.size() != 0);
  endtask

  function automatic logic [7:0] mixed_case(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) return c - 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] path_byte();
    case ($urandom_range(0, 7))
      0: return CH_QM;
      1: return 8'h2F;
      default: return 8'($urandom_range(8'h21, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] value_byte();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  task automatic add_word(input string s, input int n);
    int i;
    for (i = 0; i < n; i++) req_text.push_back(mixed_case(s[i]));
  endtask

  task automatic add_line_end();
    req_text.push_back(CH_CR);
    if ($urandom_range(0, 3) != 0) req_text.push_back(CH_LF);
  endtask

  // Assemble one plausible request: method, path with queries, version, headers, end
  task automatic build_request();
    int    m;
    int    kind;
    string w;
    req_text.delete();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: m = 0;
      4, 5, 6:    m = 1;
      default:    m = $urandom_range(2, 7);
    endcase
    w = method_text(m);
    if ($urandom_range(0, 11) == 0) begin
      // broken keyword: cut it short and add a stray byte
      add_word(w, $urandom_range(0, w.len() - 1));
      req_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_word(w, w.len());
    end
    repeat ($urandom_range(0, 6)) req_text.push_back(path_byte());
    if ($urandom_range(0, 4) != 0) begin
      req_text.push_back(CH_SP);
      add_word("http/1.0", 8);
      if ($urandom_range(0, 3) == 0) begin
        req_text.push_back(CH_QM);
        req_text.push_back(CH_SP);
      end
    end
    add_line_end();
    repeat ($urandom_range(0, 3)) begin
      kind = $urandom_range(0, 8);
      if (kind < NUM_HEADERS) begin
        w = header_text(kind);
        add_word(w, w.len());
        repeat ($urandom_range(0, 5)) req_text.push_back(value_byte());
      end else if (kind == NUM_HEADERS) begin
        // a name that no header starts with
        req_text.push_back(mixed_case(8'h78));
        repeat ($urandom_range(0, 5)) req_text.push_back(value_byte());
      end else begin
        // line ends inside a known name
        w = header_text($urandom_range(0, NUM_HEADERS - 1));
        add_word(w, $urandom_range(1, w.len() - 1));
      end
      add_line_end();
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: req_text.push_back(CH_CR);
      6, 7:             req_text.push_back(CH_NUL);
      default:          ;
    endcase
    repeat ($urandom_range(0, 2)) req_text.push_back(value_byte());
  endtask

  task automatic send_request(input int from_idx, input int to_idx);
    int i;
    for (i = from_idx; i < to_idx; i++)
      send_byte(req_text[i], (i == 0) ? ($urandom_range(0, 19) != 0)
                                      : ($urandom_range(0, 199) == 0));
  endtask

  // Directed: mixed-case GET, query restart, version with '?' and space, CRLF,
  // blank line ending the request, then a byte after the end
  task automatic test_get_with_query();
    send_text("GeT ?a?b v? ", 1'b1);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(8'h78, 1'b0);
  endtask

  task automatic test_unserved_method();
    send_text("Put x", 1'b1);
  endtask

  task automatic test_bad_keyword();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h67, 1'b0);
  endtask

  task automatic test_nul_end();
    send_text("HEAD ", 1'b1);
    send_byte(CH_NUL, 1'b0);
  endtask

  task automatic test_random_requests(input int until_count);
    while (bytes_sent < until_count) begin
      build_request();
      send_request(0, req_text.size());
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    wait_for_drain();
    hold_cycles = 150;
    repeat (3) begin
      build_request();
      send_request(0, req_text.size());
    end
  endtask

  // Sender stops mid-request until the block has caught up, then carries on
  task automatic test_drain_pause();
    int cut;
    repeat (3) begin
      build_request();
      cut = $urandom_range(1, req_text.size());
      send_request(0, cut);
      wait_for_drain();
      send_request(cut, req_text.size());
    end
  endtask

  task automatic test_noise();
    repeat (250) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  task automatic test_no_idle();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    test_random_requests(1650);
  endtask

  // Receiver side: random stall bursts, plus the long hold when one is asked for
  initial begin : result_stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_gaps_on && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_tags.size() == 0) begin
        report_mismatch("result with nothing expected", 0, out_byte_tag);
      end else begin
        want = expected_tags.pop_front();
        if (out_byte_tag !== want.byte_tag)
          report_mismatch("byte_tag", want.byte_tag, out_byte_tag);
        if (out_method_code !== want.method_code)
          report_mismatch("method_code", want.method_code, out_method_code);
        if (out_parse_status !== want.parse_status)
          report_mismatch("parse_status", want.parse_status, out_parse_status);
        if (out_header_kind !== want.header_kind)
          report_mismatch("header_kind", want.header_kind, out_header_kind);
        if (out_request_complete !== want.request_complete)
          report_mismatch("request_complete", want.request_complete, out_request_complete);
      end
    end
  end

  initial begin : run_tests
    int guard;
    clear_tagger_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_get_with_query();
    test_unserved_method();
    test_bad_keyword();
    test_nul_end();
    test_random_requests(900);
    test_backpressure();
    test_drain_pause();
    test_noise();
    test_no_idle();

    // Let the last beats come back, then give the block its latency again
    in_valid <= 1'b0;
    for (guard = 0; guard < 20000 && expected_tags.size() != 0; guard++) @(posedge clk);
    if (expected_tags.size() != 0)
      report_mismatch("results never arrived", 0, expected_tags.size());
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("http_request_line_tagger_core test passed");
    end else begin
      $display("http_request_line_tagger_core test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("http_request_line_tagger_core test failed");
    $finish;
  end

endmodule

>>> files.f
design/hrlt_pkg.sv
design/hrlt_front.sv
design/hrlt_queue.sv
design/hrlt_back.sv
design/http_request_line_tagger_core.sv
verif/tb_http_request_line_tagger_core.sv
